>>> hdl/bracket_loop_tape_machine_defines.svh
// Assertion macros used by the checker file.
`ifndef BRACKET_LOOP_TAPE_MACHINE_DEFINES_SVH
`define BRACKET_LOOP_TAPE_MACHINE_DEFINES_SVH
// Check that a condition implies a consequence on the same edge.
`define BLTM_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// Check that a condition implies a consequence on the next edge.
`define BLTM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

>>> hdl/bltm_pkg.sv
// Package with shared types, codes and constants of the tape machine.
`default_nettype none
package bltm_pkg;
  localparam int ProgDepthDefault  = 256;
  localparam int CellCountDefault  = 128;
  localparam int StackDepthDefault = 64;

  localparam logic [1:0] ACT_LOAD    = 2'd0;
  localparam logic [1:0] ACT_STEP    = 2'd1;
  localparam logic [1:0] ACT_RESTART = 2'd2;

  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_OVERFLOW  = 2'd1;
  localparam logic [1:0] ERR_UNDERFLOW = 2'd2;

  localparam logic [7:0] CH_RIGHT = 8'h3E;
  localparam logic [7:0] CH_LEFT  = 8'h3C;
  localparam logic [7:0] CH_INC   = 8'h2B;
  localparam logic [7:0] CH_DEC   = 8'h2D;
  localparam logic [7:0] CH_OUT   = 8'h2E;
  localparam logic [7:0] CH_IN    = 8'h2C;
  localparam logic [7:0] CH_OPEN  = 8'h5B;
  localparam logic [7:0] CH_CLOSE = 8'h5D;

  // One accepted item as it travels from the front part to the back part.
  typedef struct packed {
    logic [1:0] action;
    logic [7:0] prog_addr;
    logic [7:0] prog_char;
    logic [7:0] in_byte;
    logic       in_present;
  } item_t;

  typedef struct packed {
    logic       out_valid;
    logic [7:0] out_byte;
    logic       halted;
    logic [1:0] error_code;
    logic [8:0] program_counter;
  } result_t;
endpackage
`default_nettype wire

>>> hdl/bltm_queue.sv
// Small two-entry queue used between the parts of the tape machine.
`default_nettype none
module bltm_queue #(
  parameter int Width = 8
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [Width-1:0] wdata,
  output logic                  full,
  input  wire logic             pop,
  output logic [Width-1:0]      rdata,
  output logic                  empty
);
  logic [Width-1:0] slot [2];
  logic             wptr;
  logic             rptr;
  logic [1:0]       count;

  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign rdata = slot[rptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      slot[wptr] <= wdata;
    end
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push && !full) begin
        wptr <= ~wptr;
      end
      if (pop && !empty) begin
        rptr <= ~rptr;
      end
      count <= count + {1'b0, push && !full} - {1'b0, pop && !empty};
    end
  end
endmodule
`default_nettype wire

>>> hdl/bltm_engine.sv
// Execution engine: program store, tape, loop stack and the sequencer.
`default_nettype none
module bltm_engine #(
  parameter int ProgDepth  = bltm_pkg::ProgDepthDefault,
  parameter int CellCount  = bltm_pkg::CellCountDefault,
  parameter int StackDepth = bltm_pkg::StackDepthDefault
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic [8:0]       program_length,
  input  wire logic             item_valid,
  input  wire bltm_pkg::item_t  item,
  output logic                  item_take,
  output logic                  res_push,
  output bltm_pkg::result_t     res,
  input  wire logic             res_full
);
  import bltm_pkg::*;

  localparam int PW = $clog2(ProgDepth);
  localparam int CW = $clog2(CellCount);
  localparam int SW = $clog2(StackDepth);
  localparam int LW = $clog2(ProgDepth + 1);
  localparam int PCW = (LW > 9) ? LW : 9;
  localparam int AW = (PW > 8) ? PW : 8;

  localparam logic [2:0] S_IDLE      = 3'd0;
  localparam logic [2:0] S_FETCH     = 3'd1;
  localparam logic [2:0] S_EXEC      = 3'd2;
  localparam logic [2:0] S_SCAN      = 3'd3;
  localparam logic [2:0] S_CLEAR     = 3'd4;
  localparam logic [2:0] S_DONE      = 3'd5;
  localparam logic [2:0] S_SCAN_WAIT = 3'd6;
  localparam logic [2:0] S_WIPE      = 3'd7;

  logic [7:0]    prog_mem [ProgDepth];
  logic [7:0]    tape_mem [CellCount];
  logic [PCW-1:0] stack_mem [StackDepth];

  logic [2:0]     state;
  item_t          cur;
  logic [PCW-1:0] pc;
  logic [CW-1:0]  ptr;
  logic [SW:0]    sp;
  logic [1:0]     fault;
  logic [CW-1:0]  clr_idx;
  logic [PCW-1:0] scan_idx;
  logic [PCW-1:0] depth;
  logic [7:0]     op;
  logic [7:0]     cell_val;
  logic [PCW-1:0] top;
  logic [PCW-1:0] len;
  logic           ov;
  logic [7:0]     ob;
  logic [PCW-1:0] prog_rd_addr;
  logic [AW-1:0]  load_addr;

  assign len = (PCW'(program_length) < PCW'(ProgDepth)) ? PCW'(program_length)
                                                         : PCW'(ProgDepth);
  assign load_addr = AW'(item.prog_addr);
  assign item_take = (state == S_IDLE) && item_valid;
  assign res.out_valid       = ov;
  assign res.out_byte        = ob;
  assign res.error_code      = fault;
  assign res.halted          = (fault != ERR_NONE) || (pc >= len);
  assign res.program_counter = pc[8:0];
  assign res_push = (state == S_DONE) && !res_full;
  assign prog_rd_addr = (state == S_SCAN) ? scan_idx : pc;

  // Registered reads of the three memories, and their writes.
  always_ff @(posedge clk) begin
    op       <= prog_mem[prog_rd_addr[PW-1:0]];
    cell_val <= tape_mem[ptr];
    top      <= stack_mem[SW'(sp - 1'b1)];
    if (state == S_IDLE && item_valid && item.action == ACT_LOAD) begin
      prog_mem[load_addr[PW-1:0]] <= item.prog_char;
    end
    if (state == S_CLEAR || state == S_WIPE) begin
      tape_mem[clr_idx] <= 8'd0;
    end else if (state == S_EXEC) begin
      if (op == CH_INC) begin
        tape_mem[ptr] <= cell_val + 8'd1;
      end else if (op == CH_DEC) begin
        tape_mem[ptr] <= cell_val - 8'd1;
      end else if (op == CH_IN && cur.in_present) begin
        tape_mem[ptr] <= cur.in_byte;
      end
    end
    if (state == S_EXEC && op == CH_OPEN && cell_val != 8'd0 &&
        sp < (SW+1)'(StackDepth)) begin
      stack_mem[sp[SW-1:0]] <= pc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_WIPE;
      pc      <= '0;
      ptr     <= '0;
      sp      <= '0;
      fault   <= ERR_NONE;
      clr_idx <= '0;
      ov      <= 1'b0;
      ob      <= 8'd0;
      cur     <= '0;
      scan_idx <= '0;
      depth   <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (item_valid) begin
            cur <= item;
            ov  <= 1'b0;
            ob  <= 8'd0;
            if (item.action == ACT_STEP && fault == ERR_NONE && pc < len) begin
              state <= S_FETCH;
            end else if (item.action == ACT_RESTART) begin
              pc      <= '0;
              ptr     <= '0;
              sp      <= '0;
              fault   <= ERR_NONE;
              clr_idx <= '0;
              state   <= S_CLEAR;
            end else begin
              state <= S_DONE;
            end
          end
        end
        S_FETCH: state <= S_EXEC;
        S_EXEC: begin
          state <= S_DONE;
          case (op)
            CH_RIGHT: begin
              ptr <= (ptr == CW'(CellCount - 1)) ? '0 : ptr + 1'b1;
              pc  <= pc + 1'b1;
            end
            CH_LEFT: begin
              ptr <= (ptr == '0) ? CW'(CellCount - 1) : ptr - 1'b1;
              pc  <= pc + 1'b1;
            end
            CH_OUT: begin
              ov <= 1'b1;
              ob <= cell_val;
              pc <= pc + 1'b1;
            end
            CH_OPEN: begin
              if (cell_val == 8'd0) begin
                scan_idx <= pc + 1'b1;
                depth    <= '0;
                state    <= S_SCAN;
              end else if (sp >= (SW+1)'(StackDepth)) begin
                fault <= ERR_OVERFLOW;
              end else begin
                sp <= sp + 1'b1;
                pc <= pc + 1'b1;
              end
            end
            CH_CLOSE: begin
              if (sp == '0) begin
                fault <= ERR_UNDERFLOW;
              end else if (cell_val != 8'd0) begin
                pc <= top + 1'b1;
              end else begin
                sp <= sp - 1'b1;
                pc <= pc + 1'b1;
              end
            end
            default: pc <= pc + 1'b1;
          endcase
        end
        S_SCAN: begin
          // Issue the read of scan_idx here; the character is seen in the
          // wait state, so each character takes a pass through both states.
          if (scan_idx >= len) begin
            pc    <= len;
            state <= S_DONE;
          end else begin
            state <= S_SCAN_WAIT;
          end
        end
        S_SCAN_WAIT: begin
          if (op == CH_CLOSE) begin
            if (depth == '0) begin
              pc    <= scan_idx + 1'b1;
              state <= S_DONE;
            end else begin
              depth    <= depth - 1'b1;
              scan_idx <= scan_idx + 1'b1;
              state    <= S_SCAN;
            end
          end else begin
            if (op == CH_OPEN) begin
              depth <= depth + 1'b1;
            end
            scan_idx <= scan_idx + 1'b1;
            state    <= S_SCAN;
          end
        end
        S_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == CW'(CellCount - 1)) begin
            state <= S_DONE;
          end
        end
        S_WIPE: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == CW'(CellCount - 1)) begin
            state <= S_IDLE;
          end
        end
        S_DONE: begin
          if (!res_full) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

>>> hdl/bracket_loop_tape_machine.sv
// Top level of the bracket-loop tape machine.
// Usage:
//   Input channel: drive action and the payload fields, raise push; the
//   transaction completes at a clock edge where full is low. Load writes a
//   program character, step runs one instruction, restart clears the tape,
//   pointer, loop stack, pc and fault.
//   Result channel: while empty is low the oldest result is on the result
//   ports; raise pop to take it. Every input transaction yields one result.
//   program_length is to be written through cfg_we/cfg_data while idle;
//   the user is bound to this, the block does not enforce it.
// Sequencing: load or halted step goes straight to hand-off; running step
//   runs store fetch, tape read, execute, hand-off. Forward skip on a zero
//   cell: scan, then wait, per character. Restart: one tape cell a cycle.
// A two-entry input queue and two-entry result queue decouple both sides:
//   when pop is held low, results queue up, then the engine holds and the
//   input queue fills and raises full.
// Reset: clears pc, pointer, stack count, fault and program_length, then
//   sweeps the tape to zero, one cell a cycle; input transactions queue up
//   and wait for the sweep to finish.
`default_nettype none
module bracket_loop_tape_machine #(
  parameter int ProgDepth  = bltm_pkg::ProgDepthDefault,
  parameter int CellCount  = bltm_pkg::CellCountDefault,
  parameter int StackDepth = bltm_pkg::StackDepthDefault
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_we,
  input  wire logic [8:0] cfg_data,
  input  wire logic       push,
  output logic            full,
  input  wire logic [1:0] action,
  input  wire logic [7:0] prog_addr,
  input  wire logic [7:0] prog_char,
  input  wire logic [7:0] in_byte,
  input  wire logic       in_present,
  output logic            empty,
  input  wire logic       pop,
  output logic            out_valid,
  output logic [7:0]      out_byte,
  output logic            halted,
  output logic [1:0]      error_code,
  output logic [8:0]      program_counter
);
  import bltm_pkg::*;

  logic [8:0] program_length;
  item_t      in_item;
  item_t      q_item;
  logic       q_empty;
  logic       take;
  logic       res_push;
  logic       res_full;
  result_t    res;
  result_t    res_out;

  // Hold the program length register.
  always_ff @(posedge clk) begin
    if (rst) begin
      program_length <= 9'd0;
    end else if (cfg_we) begin
      program_length <= cfg_data;
    end
  end

  assign in_item = '{action: action, prog_addr: prog_addr, prog_char: prog_char,
                     in_byte: in_byte, in_present: in_present};

  bltm_queue #(.Width($bits(item_t))) u_in_q (
    .clk(clk), .rst(rst), .push(push), .wdata(in_item), .full(full),
    .pop(take), .rdata(q_item), .empty(q_empty)
  );

  bltm_engine #(
    .ProgDepth(ProgDepth), .CellCount(CellCount), .StackDepth(StackDepth)
  ) u_engine (
    .clk(clk), .rst(rst), .program_length(program_length),
    .item_valid(!q_empty), .item(q_item), .item_take(take),
    .res_push(res_push), .res(res), .res_full(res_full)
  );

  bltm_queue #(.Width($bits(result_t))) u_out_q (
    .clk(clk), .rst(rst), .push(res_push), .wdata(res), .full(res_full),
    .pop(pop), .rdata(res_out), .empty(empty)
  );

  assign out_valid       = res_out.out_valid;
  assign out_byte        = res_out.out_byte;
  assign halted          = res_out.halted;
  assign error_code      = res_out.error_code;
  assign program_counter = res_out.program_counter;
endmodule
`default_nettype wire

>>> hdl/bltm_checker.sv
// Port-level checker for the tape machine and its bind statement.
`default_nettype none
`include "bracket_loop_tape_machine_defines.svh"
module bltm_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       empty,
  input wire logic       pop,
  input wire logic       out_valid,
  input wire logic [7:0] out_byte,
  input wire logic       halted,
  input wire logic [1:0] error_code
);
  import bltm_pkg::*;
  `BLTM_ASSERT_SAME(a_err_halts, !empty && error_code != ERR_NONE, halted)
  `BLTM_ASSERT_SAME(a_err_code, !empty, error_code != 2'd3)
  `BLTM_ASSERT_SAME(a_quiet_byte, !empty && !out_valid, out_byte == 8'd0)
  `BLTM_ASSERT_NEXT(a_hold, !empty && !pop, !empty)
endmodule
bind bracket_loop_tape_machine bltm_checker u_bltm_checker (
  .clk(clk), .rst(rst), .empty(empty), .pop(pop), .out_valid(out_valid),
  .out_byte(out_byte), .halted(halted), .error_code(error_code)
);
`default_nettype wire
